### hw/rtl/pfes_pkg.sv
package pfes_pkg;

	// fixed field widths
	localparam int LEN_W = 48;
	localparam int PL_W = 27;
	localparam int FC_W = 7;
	localparam int ACT_W = 2;
	localparam int SLOT_W = 6;
	localparam int FNUM_W = 6;
	localparam int CFG_IDX_W = 2;

	// defaults
	localparam int MAX_FILES_DEF = 64;
	localparam logic [PL_W-1:0] PIECE_LEN_RST = PL_W'(262144);

	// item actions
	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD = 2'd0,
		ACT_MAP = 2'd1,
		ACT_RESTART = 2'd2
	} action_t;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIECE_LEN = 2'd0,
		REG_TOTAL_LEN = 2'd1,
		REG_FILE_COUNT = 2'd2
	} reg_idx_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_SETUP,
		ST_STEP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_wr;
		logic rewind;
		logic map_go;
		logic first_map;
		logic prime;
		logic setup;
		logic step;
	} pfes_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic started;
		logic out_free;
		logic step_done;
	} pfes_stat_t;

endpackage

### hw/rtl/pfes_ram.sv
module pfes_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/pfes_ctrl.sv
module pfes_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [pfes_pkg::ACT_W-1:0]      action,
	input  pfes_pkg::pfes_stat_t            stat,
	output logic                            in_stall,
	output pfes_pkg::pfes_cmd_t             cmd
);

	import pfes_pkg::*;

	state_t state_q, state_d;
	logic   accept;
	logic   act_load, act_map, act_restart;

	// action decode
	always_comb begin
		act_load = 1'b0;
		act_map = 1'b0;
		act_restart = 1'b0;
		unique case (action_t'(action))
			ACT_LOAD: act_load = 1'b1;
			ACT_MAP: act_map = 1'b1;
			ACT_RESTART: act_restart = 1'b1;
			default: ;
		endcase
	end

	assign accept = in_valid && (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && act_map) begin
					state_d = stat.started ? ST_SETUP : ST_PRIME;
				end
			end
			ST_PRIME: state_d = ST_SETUP;
			ST_SETUP: state_d = ST_STEP;
			ST_STEP: begin
				if (stat.out_free && stat.step_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		cmd.load_wr = accept && act_load;
		cmd.rewind = accept && act_restart;
		cmd.map_go = accept && act_map;
		cmd.first_map = accept && act_map && !stat.started;
		cmd.prime = (state_q == ST_PRIME);
		cmd.setup = (state_q == ST_SETUP);
		cmd.step = (state_q == ST_STEP) && stat.out_free;
	end

endmodule

### hw/rtl/pfes_dpath.sv
module pfes_dpath #(
	parameter int MAX_FILES = pfes_pkg::MAX_FILES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pfes_pkg::pfes_cmd_t                cmd,
	output pfes_pkg::pfes_stat_t               stat,
	input  logic                               cfg_we,
	input  logic [pfes_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfes_pkg::LEN_W-1:0]         cfg_data,
	input  logic [pfes_pkg::SLOT_W-1:0]        file_slot,
	input  logic [pfes_pkg::LEN_W-1:0]         file_bytes,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pfes_pkg::LEN_W-1:0]         piece_number,
	output logic [pfes_pkg::FNUM_W-1:0]        file_number,
	output logic [pfes_pkg::LEN_W-1:0]         file_offset,
	output logic [pfes_pkg::PL_W-1:0]          extent_bytes,
	output logic                               last,
	output logic                               fault
);

	import pfes_pkg::*;

	localparam int AW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
	localparam int CW = $clog2(MAX_FILES + 1) + 1;

	// configuration registers
	logic [PL_W-1:0]  piece_len_q;
	logic [LEN_W-1:0] total_len_q;
	logic [FC_W-1:0]  file_count_q;

	// walk state
	logic [CW-1:0]    cur_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] cons_q;
	logic [LEN_W-1:0] next_piece_q;
	logic [LEN_W-1:0] bytes_left_q;
	logic             started_q;
	logic [PL_W-1:0]  prem_q;
	logic [PL_W-1:0]  plen_q;
	logic             first_q;
	logic             empty_q;
	logic             out_valid_q;

	logic [CW-1:0]    fc;
	logic [CW-1:0]    cur_p1, cur_p2;
	logic [LEN_W-1:0] prem_x;
	logic             rem_gt, rem_eq, rem_lt;
	logic             fast, flt, take, full, done, advance;
	logic [PL_W-1:0]  pl_min1, plen;
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [LEN_W-1:0] ram_rdata;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piece_len_q <= PIECE_LEN_RST;
			total_len_q <= '0;
			file_count_q <= FC_W'(1);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PIECE_LEN: piece_len_q <= cfg_data[PL_W-1:0];
				REG_TOTAL_LEN: total_len_q <= cfg_data;
				REG_FILE_COUNT: file_count_q <= cfg_data[FC_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped file count
	always_comb begin
		if (file_count_q == '0) begin
			fc = CW'(1);
		end else if (file_count_q > FC_W'(MAX_FILES)) begin
			fc = CW'(MAX_FILES);
		end else begin
			fc = CW'(file_count_q);
		end
	end

	assign cur_p1 = cur_q + CW'(1);
	assign cur_p2 = cur_q + CW'(2);

	// length table, next entry is prefetched one step ahead
	assign ram_we = cmd.load_wr && (FC_W'(file_slot) < FC_W'(MAX_FILES));
	assign ram_re = cmd.map_go || cmd.prime || cmd.step;
	always_comb begin
		if (cmd.first_map) begin
			ram_raddr = '0;
		end else if (cmd.step) begin
			ram_raddr = cur_p2[AW-1:0];
		end else begin
			ram_raddr = cur_p1[AW-1:0];
		end
	end

	pfes_ram #(
		.WIDTH(LEN_W),
		.DEPTH(MAX_FILES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(file_slot[AW-1:0]),
		.wdata(file_bytes),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// piece length for this item
	always_comb begin
		pl_min1 = (piece_len_q == '0) ? PL_W'(1) : piece_len_q;
		plen = (LEN_W'(pl_min1) > bytes_left_q) ? bytes_left_q[PL_W-1:0] : pl_min1;
	end

	// one extent decision
	always_comb begin
		prem_x = LEN_W'(prem_q);
		rem_gt = rem_q > prem_x;
		rem_eq = rem_q == prem_x;
		rem_lt = rem_q < prem_x;
		fast = !empty_q && first_q && (cur_q < fc) && !rem_lt;
		flt = empty_q || (!fast && ((cur_q >= fc) || (rem_lt && (cur_p1 >= fc))));
		take = !flt && (fast || rem_gt);
		full = !flt && !take;
		done = flt || take || (full && rem_eq);
		advance = done && !flt;
	end

	// walk state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			rem_q <= '0;
			cons_q <= '0;
			next_piece_q <= '0;
			bytes_left_q <= '0;
			started_q <= 1'b0;
		end else if (cmd.rewind) begin
			cur_q <= '0;
			rem_q <= '0;
			cons_q <= '0;
			next_piece_q <= '0;
			bytes_left_q <= total_len_q;
			started_q <= 1'b0;
		end else if (cmd.first_map) begin
			cur_q <= '0;
			cons_q <= '0;
			bytes_left_q <= total_len_q;
			started_q <= 1'b1;
		end else if (cmd.prime) begin
			rem_q <= ram_rdata;
		end else if (cmd.step) begin
			if (take) begin
				rem_q <= rem_q - prem_x;
				cons_q <= cons_q + prem_x;
			end else if (full) begin
				cur_q <= cur_p1;
				rem_q <= (cur_p1 < fc) ? ram_rdata : '0;
				cons_q <= '0;
			end
			if (advance) begin
				next_piece_q <= next_piece_q + LEN_W'(1);
				bytes_left_q <= bytes_left_q - LEN_W'(plen_q);
			end
		end
	end

	// per item working values
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			prem_q <= plen;
			plen_q <= plen;
			first_q <= 1'b1;
			empty_q <= (bytes_left_q == '0);
		end else if (cmd.step && full) begin
			prem_q <= prem_q - rem_q[PL_W-1:0];
			first_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			piece_number <= next_piece_q;
			file_number <= flt ? '0 : FNUM_W'(cur_q);
			file_offset <= flt ? '0 : cons_q;
			extent_bytes <= flt ? '0 : (take ? prem_q : rem_q[PL_W-1:0]);
			last <= flt || take || rem_eq;
			fault <= flt;
		end
	end

	assign out_valid = out_valid_q;

	// status
	assign stat.started = started_q;
	assign stat.out_free = !out_valid_q || !out_stall;
	assign stat.step_done = done;

endmodule

### hw/rtl/piece_to_file_extent_splitter_top.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   action, file_slot, file_bytes
// out       output     out_valid / out_stall piece_number, file_number, file_offset,
//                                            extent_bytes, last, fault
// cfg       input      cfg_we                cfg_index, cfg_data
//
// load, restart and unused items do not hold the input; a map item passes the setup state
// (first the prime state after reset or restart, for the table read of file zero)
// and then takes one cycle per extent while the output is free.
// the table is a registered-read ram; the next entry is prefetched while an extent goes out.
// reset clears all control state at once; the table holds nothing until loaded.
// a stalled output holds the extent stepper; the next item is taken while the last
// result still waits in the output register.
module piece_to_file_extent_splitter_top #(
	parameter int MAX_FILES = pfes_pkg::MAX_FILES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [pfes_pkg::ACT_W-1:0]         action,
	input  logic [pfes_pkg::SLOT_W-1:0]        file_slot,
	input  logic [pfes_pkg::LEN_W-1:0]         file_bytes,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pfes_pkg::LEN_W-1:0]         piece_number,
	output logic [pfes_pkg::FNUM_W-1:0]        file_number,
	output logic [pfes_pkg::LEN_W-1:0]         file_offset,
	output logic [pfes_pkg::PL_W-1:0]          extent_bytes,
	output logic                               last,
	output logic                               fault,
	input  logic                               cfg_we,
	input  logic [pfes_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfes_pkg::LEN_W-1:0]         cfg_data
);

	import pfes_pkg::*;

	pfes_cmd_t  cmd;
	pfes_stat_t stat;

	// sequencer
	pfes_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.action  (action),
		.stat    (stat),
		.in_stall(in_stall),
		.cmd     (cmd)
	);

	// table, walk state and output register
	pfes_dpath #(
		.MAX_FILES(MAX_FILES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.file_slot   (file_slot),
		.file_bytes  (file_bytes),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.piece_number(piece_number),
		.file_number (file_number),
		.file_offset (file_offset),
		.extent_bytes(extent_bytes),
		.last        (last),
		.fault       (fault)
	);

endmodule

### hw/rtl/pfes_checker.sv
module pfes_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic [pfes_pkg::ACT_W-1:0]         action,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [pfes_pkg::LEN_W-1:0]         piece_number,
	input logic [pfes_pkg::FNUM_W-1:0]        file_number,
	input logic [pfes_pkg::LEN_W-1:0]         file_offset,
	input logic [pfes_pkg::PL_W-1:0]          extent_bytes,
	input logic                               last,
	input logic                               fault
);

	import pfes_pkg::*;

	// a stalled item holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(piece_number) &&
			$stable(file_number) && $stable(file_offset) && $stable(extent_bytes) &&
			$stable(last) && $stable(fault))
		else $error("stalled output item changed");

	// a fault item ends the piece and carries no extent
	a_fault_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> last && (file_number == '0) && (file_offset == '0) &&
			(extent_bytes == '0))
		else $error("malformed fault item");

	// load, restart and unused items do not hold the input
	a_short_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action != ACT_MAP) |=> !in_stall)
		else $error("non-map item held the input");

	// a map item always occupies the walker
	a_map_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACT_MAP) |=> in_stall)
		else $error("map item did not start a walk");

endmodule

bind piece_to_file_extent_splitter_top pfes_checker u_pfes_checker (.*);

### tb/piece_to_file_extent_splitter_top_tb.sv
`timescale 1ns / 1ps

module piece_to_file_extent_splitter_top_tb;
	import pfes_pkg::*;

	localparam int N_FILES = MAX_FILES_DEF;
	localparam int RANDOM_ITEMS = 84;
	localparam int CALM_ITEMS = 30;
	localparam int DRAIN_CYCLES = N_FILES + 16;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam logic [PL_W-1:0] PL_MAX = '1;

	// one extent as it leaves the block
	typedef struct packed {
		logic [LEN_W-1:0] piece_no;
		logic [FNUM_W-1:0] file_no;
		logic [LEN_W-1:0] offset;
		logic [PL_W-1:0] span;
		logic last;
		logic fault;
	} extent_t;

	// one row of the directed script: an item or a register write
	typedef struct packed {
		logic is_reg;
		logic [ACT_W-1:0] act;
		reg_idx_t idx;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0] value;
		logic typed;
		extent_t want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_stall;
	logic [ACT_W-1:0] action;
	logic [SLOT_W-1:0] file_slot;
	logic [LEN_W-1:0] file_bytes;
	logic out_valid;
	logic out_stall;
	logic [LEN_W-1:0] piece_number;
	logic [FNUM_W-1:0] file_number;
	logic [LEN_W-1:0] file_offset;
	logic [PL_W-1:0] extent_bytes;
	logic last;
	logic fault;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0] cfg_data;

	// mirror of the splitter state
	logic [LEN_W-1:0] len_tab [N_FILES];
	logic [PL_W-1:0] piece_len_reg;
	logic [LEN_W-1:0] total_len_reg;
	logic [FC_W-1:0] file_count_reg;
	int file_at;
	logic [LEN_W-1:0] file_left;
	logic [LEN_W-1:0] file_pos;
	logic [LEN_W-1:0] piece_idx;
	logic [LEN_W-1:0] bytes_to_go;
	logic mapping_open;

	extent_t latest [$];
	extent_t extents_due [$];
	int items_done = 0;
	int mismatches = 0;
	int cycle_count = 0;
	bit send_gaps = 1'b1;
	bit stall_gaps = 1'b1;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	piece_to_file_extent_splitter_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.file_slot(file_slot),
		.file_bytes(file_bytes),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.piece_number(piece_number),
		.file_number(file_number),
		.file_offset(file_offset),
		.extent_bytes(extent_bytes),
		.last(last),
		.fault(fault),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [LEN_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[LEN_W-1:0];
	endfunction

	function automatic void note_extent(int fnum, logic [LEN_W-1:0] off,
			logic [LEN_W-1:0] len, logic is_last, logic is_fault);
		extent_t e;
		e = '{piece_idx, FNUM_W'(fnum), off, len[PL_W-1:0], is_last, is_fault};
		latest.insert(latest.size(), e);
	endfunction

	// extents caused by one item; updates the mirrored state
	function automatic void predict_extents(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] slot,
			logic [LEN_W-1:0] value);
		logic [LEN_W-1:0] plen;
		logic [LEN_W-1:0] prem;
		int fc;
		latest.delete();
		if (act == ACT_LOAD) begin
			len_tab[slot] = value;
		end else if (act == ACT_RESTART) begin
			mapping_open = 1'b0;
			piece_idx = '0;
			file_at = 0;
			file_left = '0;
			file_pos = '0;
			bytes_to_go = total_len_reg;
		end else if (act == ACT_MAP) begin
			// first map after reset or restart picks up file zero
			if (!mapping_open) begin
				bytes_to_go = total_len_reg;
				file_at = 0;
				file_left = len_tab[0];
				file_pos = '0;
				mapping_open = 1'b1;
			end
			// past the end of the byte space
			if (bytes_to_go == 0) begin
				note_extent(0, '0, '0, 1'b1, 1'b1);
				return;
			end
			plen = (piece_len_reg == 0) ? LEN_W'(1) : LEN_W'(piece_len_reg);
			if (plen > bytes_to_go)
				plen = bytes_to_go;
			fc = (file_count_reg == 0) ? 1 :
				(file_count_reg > N_FILES) ? N_FILES : int'(file_count_reg);
			if (file_at < fc && file_left >= plen) begin
				note_extent(file_at, file_pos, plen, 1'b1, 1'b0);
				file_left -= plen;
				file_pos += plen;
			end else begin
				// walk across file boundaries
				prem = plen;
				while (prem != 0) begin
					if (file_at >= fc || (file_left < prem && file_at + 1 >= fc)) begin
						note_extent(0, '0, '0, 1'b1, 1'b1);
						return;
					end
					if (file_left <= prem) begin
						note_extent(file_at, file_pos, file_left, file_left == prem, 1'b0);
						prem -= file_left;
						file_at++;
						file_left = (file_at < fc) ? len_tab[file_at] : '0;
						file_pos = '0;
					end else begin
						note_extent(file_at, file_pos, prem, 1'b1, 1'b0);
						file_left -= prem;
						file_pos += prem;
						prem = '0;
					end
				end
			end
			piece_idx += LEN_W'(1);
			bytes_to_go -= plen;
		end
	endfunction

	function automatic step_t item_step(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] slot,
			logic [LEN_W-1:0] value);
		step_t s = '0;
		s.act = act;
		s.slot = slot;
		s.value = value;
		return s;
	endfunction

	function automatic step_t reg_step(reg_idx_t idx, logic [LEN_W-1:0] value);
		step_t s = '0;
		s.is_reg = 1'b1;
		s.idx = idx;
		s.value = value;
		return s;
	endfunction

	// map that must answer with the error extent
	function automatic step_t fault_step(logic [LEN_W-1:0] piece);
		step_t s;
		s = item_step(ACT_MAP, '0, '0);
		s.typed = 1'b1;
		s.want = '{piece, '0, '0, '0, 1'b1, 1'b1};
		return s;
	endfunction

	// present one item and hold it until taken
	task automatic offer(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] slot,
			logic [LEN_W-1:0] value, bit use_model);
		if (!calm && send_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		file_slot <= slot;
		file_bytes <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_extents(act, slot, value);
		if (use_model)
			foreach (latest[k])
				extents_due.insert(extents_due.size(), latest[k]);
		if (act != ACT_UNUSED)
			items_done++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [LEN_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PIECE_LEN: piece_len_reg = value[PL_W-1:0];
			REG_TOTAL_LEN: total_len_reg = value;
			REG_FILE_COUNT: file_count_reg = value[FC_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// stop sending, let every extent out, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (extents_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// output side: random stall bursts and one long hold-off
	initial begin : receiver
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && stall_gaps && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare each extent taken with the oldest one pending
	always @(posedge clk) begin : extent_check
		extent_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (extents_due.size() == 0) begin
				$error("extent with none pending: piece %0d file %0d", piece_number,
					file_number);
				mismatches++;
			end else begin
				want = extents_due.pop_front();
				if (piece_number !== want.piece_no) begin
					$error("piece_number: expected %0d, got %0d", want.piece_no, piece_number);
					mismatches++;
				end
				if (file_number !== want.file_no) begin
					$error("file_number: expected %0d, got %0d", want.file_no, file_number);
					mismatches++;
				end
				if (file_offset !== want.offset) begin
					$error("file_offset: expected %0d, got %0d", want.offset, file_offset);
					mismatches++;
				end
				if (extent_bytes !== want.span) begin
					$error("extent_bytes: expected %0d, got %0d", want.span, extent_bytes);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					mismatches++;
				end
				if (fault !== want.fault) begin
					$error("fault: expected %0b, got %0b", want.fault, fault);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		step_t script [$];
		logic [LEN_W-1:0] plan [N_FILES];
		logic [SLOT_W-1:0] load_slots [8];
		logic [PL_W-1:0] pl_pick;
		logic [LEN_W-1:0] sum;
		logic [LEN_W-1:0] total_pick;
		int rand_base;
		int phase_no;
		int fc_pick;
		int fc_eff;
		int n_loads;
		int map_cap;
		int len_cap;
		int r;
		bit prev_reg;
		bit saw_end;

		// known levels on every input from time zero
		in_valid = 1'b0;
		action = ACT_LOAD;
		file_slot = '0;
		file_bytes = '0;
		cfg_we = 1'b0;
		cfg_index = REG_PIECE_LEN;
		cfg_data = '0;
		piece_len_reg = PIECE_LEN_RST;
		total_len_reg = '0;
		file_count_reg = FC_W'(1);
		file_at = 0;
		file_left = '0;
		file_pos = '0;
		piece_idx = '0;
		bytes_to_go = '0;
		mapping_open = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole length table so no read ever finds an unwritten entry
		for (int i = 0; i < N_FILES; i++)
			offer(ACT_LOAD, SLOT_W'(i), LEN_W'($urandom_range(0, 15)), 1'b1);

		// directed script
		script.insert(script.size(), fault_step(LEN_W'(0)));
		script.insert(script.size(), item_step(ACT_UNUSED, '1, LEN_MAX));
		// three files, one empty, pieces of four bytes
		script.insert(script.size(), reg_step(REG_PIECE_LEN, LEN_W'(4)));
		script.insert(script.size(), reg_step(REG_TOTAL_LEN, LEN_W'(10)));
		script.insert(script.size(), reg_step(REG_FILE_COUNT, LEN_W'(3)));
		script.insert(script.size(), item_step(ACT_LOAD, SLOT_W'(0), LEN_W'(3)));
		script.insert(script.size(), item_step(ACT_LOAD, SLOT_W'(1), LEN_W'(0)));
		script.insert(script.size(), item_step(ACT_LOAD, SLOT_W'(2), LEN_W'(7)));
		script.insert(script.size(), item_step(ACT_RESTART, '0, '0));
		script.insert(script.size(), item_step(ACT_MAP, '0, '0));
		script.insert(script.size(), item_step(ACT_MAP, '0, '0));
		script.insert(script.size(), item_step(ACT_MAP, '0, '0));
		script.insert(script.size(), fault_step(LEN_W'(3)));
		// total beyond the files: runs out of files
		script.insert(script.size(), reg_step(REG_PIECE_LEN, LEN_W'(6)));
		script.insert(script.size(), reg_step(REG_TOTAL_LEN, LEN_W'(20)));
		script.insert(script.size(), item_step(ACT_RESTART, '0, '0));
		script.insert(script.size(), item_step(ACT_MAP, '0, '0));
		script.insert(script.size(), fault_step(LEN_W'(1)));
		script.insert(script.size(), item_step(ACT_MAP, '0, '0));
		// zero piece length and zero file count
		script.insert(script.size(), reg_step(REG_PIECE_LEN, LEN_W'(0)));
		script.insert(script.size(), reg_step(REG_FILE_COUNT, LEN_W'(0)));
		script.insert(script.size(), reg_step(REG_TOTAL_LEN, LEN_W'(2)));
		script.insert(script.size(), item_step(ACT_RESTART, '0, '0));
		script.insert(script.size(), item_step(ACT_MAP, '0, '0));
		script.insert(script.size(), item_step(ACT_MAP, '0, '0));
		script.insert(script.size(), fault_step(LEN_W'(2)));
		// widest settings: one piece across every file
		script.insert(script.size(), reg_step(REG_PIECE_LEN, LEN_W'(PL_MAX)));
		script.insert(script.size(), reg_step(REG_FILE_COUNT, LEN_W'(127)));
		script.insert(script.size(), reg_step(REG_TOTAL_LEN, LEN_MAX));
		script.insert(script.size(), item_step(ACT_LOAD, '1, LEN_MAX));
		script.insert(script.size(), item_step(ACT_RESTART, '1, LEN_MAX));
		script.insert(script.size(), item_step(ACT_MAP, '0, '0));
		script.insert(script.size(), item_step(ACT_MAP, '0, '0));

		prev_reg = 1'b0;
		foreach (script[i]) begin
			if (script[i].is_reg) begin
				if (!prev_reg)
					settle();
				write_reg(script[i].idx, script[i].value);
			end else begin
				offer(script[i].act, script[i].slot, script[i].value, !script[i].typed);
				if (script[i].typed)
					extents_due.insert(extents_due.size(), script[i].want);
			end
			prev_reg = script[i].is_reg;
		end

		// random phases: new settings, restart, table loads, then a run of maps
		rand_base = items_done;
		phase_no = 0;
		while (items_done - rand_base < RANDOM_ITEMS) begin
			settle();
			send_gaps = ($urandom_range(0, 3) != 0);
			stall_gaps = ($urandom_range(0, 3) != 0);

			// file count, some outside the legal range
			r = $urandom_range(0, 9);
			fc_pick = (r == 0) ? 0 : (r == 1) ? N_FILES :
				(r == 2) ? $urandom_range(N_FILES + 1, 127) : $urandom_range(1, 6);
			fc_eff = (fc_pick == 0) ? 1 : (fc_pick > N_FILES) ? N_FILES : fc_pick;

			// piece length, mostly small
			r = $urandom_range(0, 9);
			case (r)
				0: pl_pick = '0;
				1: pl_pick = PL_MAX;
				2: pl_pick = PL_W'(1 << 26);
				3: pl_pick = PL_W'($urandom());
				default: pl_pick = PL_W'($urandom_range(1, 12));
			endcase
			len_cap = (pl_pick > 4096) ? 2 * int'(pl_pick) : 2 * int'(pl_pick) + 2;

			// file lengths to load, on a copy of the table
			plan = len_tab;
			n_loads = (fc_eff <= 8) ? fc_eff : $urandom_range(2, 6);
			for (int k = 0; k < n_loads; k++) begin
				load_slots[k] = (fc_eff <= 8) ? SLOT_W'(k) :
					SLOT_W'($urandom_range(0, fc_eff - 1));
				r = $urandom_range(0, 9);
				plan[load_slots[k]] = (r == 0) ? '0 : (r == 1) ? rand48() :
					LEN_W'($urandom_range(0, len_cap));
			end

			// total length: mostly the exact sum of the files in use
			sum = '0;
			for (int k = 0; k < fc_eff; k++)
				sum += plan[k];
			r = $urandom_range(0, 9);
			case (r)
				0: total_pick = '0;
				1: total_pick = rand48();
				2: total_pick = sum + LEN_W'($urandom_range(1, 40));
				3: total_pick = sum - (sum >> $urandom_range(1, 4));
				default: total_pick = sum;
			endcase

			write_reg(REG_PIECE_LEN, LEN_W'(pl_pick));
			write_reg(REG_TOTAL_LEN, total_pick);
			write_reg(REG_FILE_COUNT, LEN_W'(fc_pick));
			offer(ACT_RESTART, SLOT_W'($urandom()), rand48(), 1'b1);
			for (int k = 0; k < n_loads; k++)
				offer(ACT_LOAD, load_slots[k], plan[load_slots[k]], 1'b1);

			// first phase: output held off while maps keep coming
			if (phase_no == 0)
				hold_req = 1'b1;

			// maps with a little noise, until the cap or, at random, a fault extent
			map_cap = $urandom_range(4, 14);
			saw_end = 1'b0;
			for (int k = 0; k < map_cap && !saw_end &&
					items_done - rand_base < RANDOM_ITEMS; k++) begin
				if (items_done - rand_base >= RANDOM_ITEMS - CALM_ITEMS)
					calm = 1'b1;
				r = $urandom_range(0, 19);
				if (r == 0)
					offer(ACT_UNUSED, SLOT_W'($urandom()), rand48(), 1'b1);
				else if (r == 1)
					offer(ACT_LOAD, SLOT_W'($urandom()), rand48(), 1'b1);
				else if (r == 2)
					offer(ACT_RESTART, SLOT_W'($urandom()), rand48(), 1'b1);
				offer(ACT_MAP, SLOT_W'($urandom()), rand48(), 1'b1);
				if (latest[$].fault && $urandom_range(0, 1) == 0)
					saw_end = 1'b1;
			end
			phase_no++;
		end

		settle();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
